// ----- sv/vsp_pkg.sv -----
// Shared types, constants and helpers for the vertex screen projection block.
package vsp_pkg;

    localparam int COMP_W    = 21;          // one signed vector component
    localparam int VEC_W     = 3 * COMP_W;  // packed x, y, z
    localparam int DIM_W     = 13;          // screen width / height
    localparam int FOV_W     = 16;          // unsigned Q2.14
    localparam int NEAR_W    = 21;
    localparam int FAR_W     = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = VEC_W;
    localparam int PIX_W     = 32;

    localparam int COORD_FRAC_BITS_DEF = 12;

    localparam logic [VEC_W-1:0]         CAMERA_RST = 63'd2076672;
    localparam logic [VEC_W-1:0]         VIEW_RST   = 63'd4096;
    localparam logic [VEC_W-1:0]         RIGHT_RST  = 63'd0;
    localparam logic [VEC_W-1:0]         UP_RST     = 63'd18014398509481984;
    localparam logic [FOV_W-1:0]         FOV_RST    = 16'd12288;
    localparam logic signed [NEAR_W-1:0] NEAR_RST   = 21'sd41;
    localparam logic [FAR_W-1:0]         FAR_RST    = 20'd409600;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAMERA = 3'd0,
        CFG_VIEW   = 3'd1,
        CFG_RIGHT  = 3'd2,
        CFG_UP     = 3'd3,
        CFG_FOV    = 3'd4,
        CFG_NEAR   = 3'd5,
        CFG_FAR    = 3'd6,
        CFG_ORTHO  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [VEC_W-1:0]         camera;
        logic [VEC_W-1:0]         view;
        logic [VEC_W-1:0]         right;
        logic [VEC_W-1:0]         up;
        logic [FOV_W-1:0]         fov;
        logic signed [NEAR_W-1:0] near_lim;
        logic [FAR_W-1:0]         far_lim;
        logic                     ortho;
    } t_cfg;

    function automatic logic signed [COMP_W-1:0] comp(input logic [VEC_W-1:0] v,
                                                      input int unsigned k);
        return $signed(v[k*COMP_W +: COMP_W]);
    endfunction

endpackage

// ----- sv/vsp_cfg_regs.sv -----
// Camera and projection configuration registers.
module vsp_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [vsp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vsp_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output vsp_pkg::t_cfg                 o_cfg
);

    vsp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.camera   <= vsp_pkg::CAMERA_RST;
            r_cfg.view     <= vsp_pkg::VIEW_RST;
            r_cfg.right    <= vsp_pkg::RIGHT_RST;
            r_cfg.up       <= vsp_pkg::UP_RST;
            r_cfg.fov      <= vsp_pkg::FOV_RST;
            r_cfg.near_lim <= vsp_pkg::NEAR_RST;
            r_cfg.far_lim  <= vsp_pkg::FAR_RST;
            r_cfg.ortho    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (vsp_pkg::t_cfg_idx'(i_cfg_index))
                vsp_pkg::CFG_CAMERA: r_cfg.camera   <= i_cfg_data;
                vsp_pkg::CFG_VIEW:   r_cfg.view     <= i_cfg_data;
                vsp_pkg::CFG_RIGHT:  r_cfg.right    <= i_cfg_data;
                vsp_pkg::CFG_UP:     r_cfg.up       <= i_cfg_data;
                vsp_pkg::CFG_FOV:    r_cfg.fov      <= i_cfg_data[vsp_pkg::FOV_W-1:0];
                vsp_pkg::CFG_NEAR:   r_cfg.near_lim <= $signed(i_cfg_data[vsp_pkg::NEAR_W-1:0]);
                vsp_pkg::CFG_FAR:    r_cfg.far_lim  <= i_cfg_data[vsp_pkg::FAR_W-1:0];
                vsp_pkg::CFG_ORTHO:  r_cfg.ortho    <= i_cfg_data[0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/vsp_sqrt_pipe.sv -----
// Pipelined integer square root, one result bit per stage.
module vsp_sqrt_pipe #(
    parameter int S_W    = 44,
    parameter int SIDE_W = 1
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [S_W-1:0]     i_s,
    input  logic [SIDE_W-1:0]  i_side,
    output logic [S_W/2-1:0]   o_root,
    output logic [SIDE_W-1:0]  o_side
);

    localparam int R_W = S_W / 2;

    logic [R_W:0]      w_rem  [0:R_W];
    logic [R_W-1:0]    w_root [0:R_W];
    logic [S_W-1:0]    w_s    [0:R_W];
    logic [SIDE_W-1:0] w_side [0:R_W];

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_s[0]    = i_s;
    assign w_side[0] = i_side;

    for (genvar g = 0; g < R_W; g++) begin : g_stage
        logic [R_W+1:0]    t_rem;
        logic [R_W+1:0]    t_trial;
        logic              t_ge;
        logic [R_W:0]      r_rem;
        logic [R_W-1:0]    r_root;
        logic [S_W-1:0]    r_s;
        logic [SIDE_W-1:0] r_side;

        // bring down the next two radicand bits, try root*4+1
        assign t_rem   = {w_rem[g][R_W-1:0], w_s[g][S_W-1 -: 2]};
        assign t_trial = {w_root[g], 2'b01};
        assign t_ge    = (t_rem >= t_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= t_ge ? (R_W+1)'(t_rem - t_trial) : t_rem[R_W:0];
                r_root <= {w_root[g][R_W-2:0], t_ge};
                r_s    <= {w_s[g][S_W-3:0], 2'b00};
                r_side <= w_side[g];
            end
        end

        assign w_rem[g+1]  = r_rem;
        assign w_root[g+1] = r_root;
        assign w_s[g+1]    = r_s;
        assign w_side[g+1] = r_side;
    end

    assign o_root = w_root[R_W];
    assign o_side = w_side[R_W];

endmodule

// ----- sv/vsp_div_pipe.sv -----
// Pipelined restoring unsigned divider, one quotient bit per stage.
module vsp_div_pipe #(
    parameter int NUM_W  = 33,
    parameter int DEN_W  = 22,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic [NUM_W-1:0]  o_quo,
    output logic [DEN_W-1:0]  o_rem,
    output logic [SIDE_W-1:0] o_side
);

    logic [NUM_W-1:0]  w_n    [0:NUM_W];
    logic [DEN_W-1:0]  w_r    [0:NUM_W];
    logic [DEN_W-1:0]  w_d    [0:NUM_W];
    logic [SIDE_W-1:0] w_side [0:NUM_W];

    assign w_n[0]    = i_num;
    assign w_r[0]    = '0;
    assign w_d[0]    = i_den;
    assign w_side[0] = i_side;

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic [DEN_W:0]    t_part;
        logic              t_ge;
        logic [NUM_W-1:0]  r_n;
        logic [DEN_W-1:0]  r_r;
        logic [DEN_W-1:0]  r_d;
        logic [SIDE_W-1:0] r_side;

        // numerator shifts out the top, quotient bits shift in at the bottom
        assign t_part = {w_r[g], w_n[g][NUM_W-1]};
        assign t_ge   = (t_part >= {1'b0, w_d[g]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r    <= t_ge ? DEN_W'(t_part - {1'b0, w_d[g]}) : t_part[DEN_W-1:0];
                r_n    <= {w_n[g][NUM_W-2:0], t_ge};
                r_d    <= w_d[g];
                r_side <= w_side[g];
            end
        end

        assign w_n[g+1]    = r_n;
        assign w_r[g+1]    = r_r;
        assign w_d[g+1]    = r_d;
        assign w_side[g+1] = r_side;
    end

    assign o_quo  = w_n[NUM_W];
    assign o_rem  = w_r[NUM_W];
    assign o_side = w_side[NUM_W];

endmodule

// ----- sv/vertex_screen_projection_unit.sv -----
// Vertex screen projection top level: camera transform, clipping and pixel mapping.
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+---------------------------------------------
//  s (in)   | in  | i_s_tvalid / o_s_tready    | i_s_tdata: vert_x, vert_y, vert_z, w, h
//  m (out)  | out | o_m_tvalid / i_m_tready    | o_m_tdata: pixel_x, pixel_y; o_m_tuser: visible
//  cfg      | in  | i_cfg_wr_en                | i_cfg_index, i_cfg_data
//
// One vertex per cycle sustained while the output is not stalled. The pipeline holds the square
// root stages (22), the normalizing dividers (21+F stages) and the pixel dividers (81-2F stages).
// Synchronous active-low reset clears the valid bits and loads the configuration registers with their reset values.
// A stall on the output freezes the whole pipeline; bubbles are carried, nothing is dropped.
module vertex_screen_projection_unit #(
    parameter int COORD_FRAC_BITS = vsp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [20:0] vert_x, [41:21] vert_y, [62:42] vert_z, [75:63] screen_width,
    // [88:76] screen_height, [95:89] zero
    input  logic [95:0]                   i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [31:0] pixel_x, [63:32] pixel_y
    output logic [63:0]                   o_m_tdata,
    // [0] visible
    output logic [0:0]                    o_m_tuser,
    input  logic                          i_cfg_wr_en,
    input  logic [vsp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vsp_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int F       = COORD_FRAC_BITS;
    localparam int CW      = vsp_pkg::COMP_W;
    localparam int DW      = vsp_pkg::DIM_W;
    localparam int D_W     = CW + 1;               // v - c
    localparam int MAG_W   = CW;                   // |v - c|
    localparam int SQ_W    = 2 * D_W;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int NDIV_W  = MAG_W + F;
    localparam int PR_W    = D_W + CW;
    localparam int ACC_W   = PR_W + 2;
    localparam int DOT_W   = ACC_W - F;
    localparam int PP_W    = DOT_W + DW + 1;
    localparam int PSHIFT  = 22 - F;
    localparam int PNUM_W  = PP_W + PSHIFT;
    localparam int Q_W     = PNUM_W + 1;
    localparam int SUM_W   = PNUM_W + 2;
    localparam int FOV_W   = vsp_pkg::FOV_W;
    localparam int PIX_W   = vsp_pkg::PIX_W;
    localparam int LAT     = 3 + ROOT_W + NDIV_W + 5 + PNUM_W + 2;

    localparam logic signed [PIX_W-1:0] P_MAX = 32'sh7fffffff;
    localparam logic signed [PIX_W-1:0] P_MIN = 32'sh80000000;

    typedef struct packed {
        logic [DW-1:0]           w;
        logic [DW-1:0]           h;
        logic [2:0][D_W-1:0]     d;
        logic [2:0][MAG_W-1:0]   mag;
    } t_sq_side;

    typedef struct packed {
        logic                    len_zero;
        logic [DW-1:0]           w;
        logic [DW-1:0]           h;
        logic [D_W-1:0]          d;
    } t_n0_side;

    typedef struct packed {
        logic                    neg;
        logic                    vis;
        logic [DW-1:0]           w;
        logic [DW-1:0]           h;
    } t_px_side;

    function automatic logic [PIX_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [PIX_W-1:0] res;
        if (v > SUM_W'(P_MAX)) begin
            res = P_MAX;
        end else if (v < SUM_W'(P_MIN)) begin
            res = P_MIN;
        end else begin
            res = v[PIX_W-1:0];
        end
        return res;
    endfunction

    vsp_pkg::t_cfg cfg;

    vsp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    logic           en;
    logic [LAT-1:0] r_vld;

    assign en         = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // ---- difference to camera
    logic signed [D_W-1:0] r_d [3];
    logic [DW-1:0]         r_w1, r_h1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= D_W'($signed(i_s_tdata[k*CW +: CW]))
                        - D_W'(vsp_pkg::comp(cfg.camera, k));
            end
            r_w1 <= i_s_tdata[3*CW +: DW];
            r_h1 <= i_s_tdata[3*CW+DW +: DW];
        end
    end

    // ---- squares and magnitudes
    logic signed [SQ_W-1:0] r_sq [3];
    t_sq_side               r_sd2, r_sd3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k]       <= r_d[k] * r_d[k];
                r_sd2.d[k]    <= r_d[k];
                r_sd2.mag[k]  <= r_d[k][D_W-1] ? MAG_W'(-r_d[k]) : MAG_W'(r_d[k]);
            end
            r_sd2.w <= r_w1;
            r_sd2.h <= r_h1;
        end
    end

    logic [SQ_W-1:0] r_ssum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ssum <= r_sq[0] + r_sq[1] + r_sq[2];
            r_sd3  <= r_sd2;
        end
    end

    // ---- length
    logic [ROOT_W-1:0] sq_root;
    t_sq_side          sq_side;

    vsp_sqrt_pipe #(
        .S_W    (SQ_W),
        .SIDE_W ($bits(t_sq_side))
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_s    (r_ssum),
        .i_side (r_sd3),
        .o_root (sq_root),
        .o_side (sq_side)
    );

    // ---- normalize: |d| * 2^F / len, three lanes
    t_n0_side          n0_in, n0_out;
    logic [NDIV_W-1:0] nq   [3];
    logic [ROOT_W-1:0] nrem [3];
    logic [D_W-1:0]    nd1_out, nd2_out;

    assign n0_in.len_zero = (sq_root == '0);
    assign n0_in.w        = sq_side.w;
    assign n0_in.h        = sq_side.h;
    assign n0_in.d        = sq_side.d[0];

    vsp_div_pipe #(.NUM_W(NDIV_W), .DEN_W(ROOT_W), .SIDE_W($bits(t_n0_side))) u_ndiv0 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  ({sq_side.mag[0], F'(0)}),
        .i_den  (sq_root),
        .i_side (n0_in),
        .o_quo  (nq[0]),
        .o_rem  (nrem[0]),
        .o_side (n0_out)
    );

    vsp_div_pipe #(.NUM_W(NDIV_W), .DEN_W(ROOT_W), .SIDE_W(D_W)) u_ndiv1 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  ({sq_side.mag[1], F'(0)}),
        .i_den  (sq_root),
        .i_side (sq_side.d[1]),
        .o_quo  (nq[1]),
        .o_rem  (nrem[1]),
        .o_side (nd1_out)
    );

    vsp_div_pipe #(.NUM_W(NDIV_W), .DEN_W(ROOT_W), .SIDE_W(D_W)) u_ndiv2 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  ({sq_side.mag[2], F'(0)}),
        .i_den  (sq_root),
        .i_side (sq_side.d[2]),
        .o_quo  (nq[2]),
        .o_rem  (nrem[2]),
        .o_side (nd2_out)
    );

    // remainders are not needed for truncating division
    logic nrem_unused;
    assign nrem_unused = ^{nrem[0], nrem[1], nrem[2]};

    logic signed [D_W-1:0] nd_raw [3];
    logic signed [D_W-1:0] r_dn   [3];
    logic                  r_rej5;
    logic [DW-1:0]         r_w5, r_h5;

    assign nd_raw[0] = $signed(n0_out.d);
    assign nd_raw[1] = $signed(nd1_out);
    assign nd_raw[2] = $signed(nd2_out);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                if (cfg.ortho) begin
                    r_dn[k] <= nd_raw[k];
                end else if (nd_raw[k][D_W-1]) begin
                    r_dn[k] <= -$signed(D_W'(nq[k]));
                end else begin
                    r_dn[k] <= $signed(D_W'(nq[k]));
                end
            end
            // zero-length difference only matters in perspective mode
            r_rej5 <= !cfg.ortho && n0_out.len_zero && !nrem_unused || 
                      !cfg.ortho && n0_out.len_zero && nrem_unused;
            r_w5   <= n0_out.w;
            r_h5   <= n0_out.h;
        end
    end

    // ---- axis products: 0 view normal, 1 right, 2 up
    logic signed [PR_W-1:0] r_pr [3][3];
    logic                   r_rej6;
    logic [DW-1:0]          r_w6, r_h6;
    logic [vsp_pkg::VEC_W-1:0] axis [3];

    assign axis[0] = cfg.view;
    assign axis[1] = cfg.right;
    assign axis[2] = cfg.up;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_pr[j][k] <= r_dn[k] * vsp_pkg::comp(axis[j], k);
                end
            end
            r_rej6 <= r_rej5;
            r_w6   <= r_w5;
            r_h6   <= r_h5;
        end
    end

    // ---- dot products, floor shift
    logic signed [ACC_W-1:0] acc [3];
    logic signed [DOT_W-1:0] r_dot [3];
    logic                    r_rej7;
    logic [DW-1:0]           r_w7, r_h7;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            acc[j] = ACC_W'(r_pr[j][0]) + ACC_W'(r_pr[j][1]) + ACC_W'(r_pr[j][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r_dot[j] <= DOT_W'(acc[j] >>> F);
            end
            r_rej7 <= r_rej6;
            r_w7   <= r_w6;
            r_h7   <= r_h6;
        end
    end

    // ---- clip test and pixel products
    logic signed [DOT_W-1:0] near_ext, far_ext;
    logic                    vis;
    logic signed [PP_W-1:0]  r_pp [2];
    logic                    r_vis8;
    logic [DW-1:0]           r_w8, r_h8;

    assign near_ext = DOT_W'(cfg.near_lim);
    assign far_ext  = $signed(DOT_W'(cfg.far_lim));
    assign vis      = !r_rej7 && (r_dot[0] > near_ext)
                   && !((cfg.far_lim != '0) && (r_dot[0] > far_ext));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pp[0] <= r_dot[1] * $signed({1'b0, r_w7});
            r_pp[1] <= r_dot[2] * $signed({1'b0, r_w7});
            r_vis8  <= vis;
            r_w8    <= r_w7;
            r_h8    <= r_h7;
        end
    end

    // ---- sign and magnitude for the divide
    logic [PP_W-1:0] r_pmag [2];
    logic            r_neg9 [2];
    logic            r_vis9;
    logic [DW-1:0]   r_w9, r_h9;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 2; i++) begin
                r_neg9[i] <= r_pp[i][PP_W-1];
                r_pmag[i] <= r_pp[i][PP_W-1] ? PP_W'(-r_pp[i]) : PP_W'(r_pp[i]);
            end
            r_vis9 <= r_vis8;
            r_w9   <= r_w8;
            r_h9   <= r_h8;
        end
    end

    // ---- pixel divide by field of view
    logic [FOV_W-1:0]  fov_den;
    t_px_side          px_in, px_out;
    logic [PNUM_W-1:0] pq   [2];
    logic [FOV_W-1:0]  prem [2];
    logic              py_neg;

    assign fov_den    = (cfg.fov == '0) ? FOV_W'(1) : cfg.fov;
    assign px_in.neg  = r_neg9[0];
    assign px_in.vis  = r_vis9;
    assign px_in.w    = r_w9;
    assign px_in.h    = r_h9;

    vsp_div_pipe #(.NUM_W(PNUM_W), .DEN_W(FOV_W), .SIDE_W($bits(t_px_side))) u_pdiv_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  ({r_pmag[0], PSHIFT'(0)}),
        .i_den  (fov_den),
        .i_side (px_in),
        .o_quo  (pq[0]),
        .o_rem  (prem[0]),
        .o_side (px_out)
    );

    vsp_div_pipe #(.NUM_W(PNUM_W), .DEN_W(FOV_W), .SIDE_W(1)) u_pdiv_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  ({r_pmag[1], PSHIFT'(0)}),
        .i_den  (fov_den),
        .i_side (r_neg9[1]),
        .o_quo  (pq[1]),
        .o_rem  (prem[1]),
        .o_side (py_neg)
    );

    // ---- floor division sign fix: negative rounds away from zero on a remainder
    logic                  qneg [2];
    logic signed [Q_W-1:0] r_q [2];
    logic                  r_vis_q;
    logic [DW-1:0]         r_w_q, r_h_q;

    assign qneg[0] = px_out.neg;
    assign qneg[1] = py_neg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 2; i++) begin
                if (qneg[i]) begin
                    r_q[i] <= -$signed(Q_W'(pq[i]) + Q_W'(prem[i] != '0));
                end else begin
                    r_q[i] <= $signed(Q_W'(pq[i]));
                end
            end
            r_vis_q <= px_out.vis;
            r_w_q   <= px_out.w;
            r_h_q   <= px_out.h;
        end
    end

    // ---- center offset, saturate, zero when not visible, output register
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic [PIX_W-1:0]        r_px, r_py;
    logic                    r_vis_o;

    assign sum_x = $signed(SUM_W'({r_w_q, 7'b0})) + SUM_W'(r_q[0]);
    assign sum_y = $signed(SUM_W'({r_h_q, 7'b0})) - SUM_W'(r_q[1]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vis_o <= r_vis_q;
            r_px    <= r_vis_q ? sat32(sum_x) : '0;
            r_py    <= r_vis_q ? sat32(sum_y) : '0;
        end
    end

    assign o_m_tdata = {r_py, r_px};
    assign o_m_tuser = r_vis_o;

endmodule
